// ===== rtl/core/rcpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared constants and codes for the rc pwm pulse capture block.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

  // channel count and the throttle channel
  localparam int NUM_CHANNELS     = 8;
  localparam int THROTTLE_CHANNEL = 2;

  // index width into the per-channel state
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // field widths
  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 4;
  localparam int STAMP_W  = 32;
  localparam int PULSE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int ENABLE_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [PULSE_W-1:0] PULSE_MIN_RST    = 16'd750;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST    = 16'd2250;
  localparam logic [STAMP_W-1:0] LOST_TIMEOUT_RST = 32'd100000;
  localparam logic [PULSE_W-1:0] MID_VALUE_RST    = 16'd1500;
  localparam logic [PULSE_W-1:0] THROTTLE_LOW_RST = 16'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_VALUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_LOW = 3'd5;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE = 2'd0,
    CMD_POLL = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  // poll answers
  typedef enum logic [STATUS_W-1:0] {
    STATUS_LOST     = 2'd0,
    STATUS_RECEIVED = 2'd1,
    STATUS_IDLE     = 2'd2
  } status_t;

endpackage

// ===== rtl/core/rc_pwm_pulse_capture_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_pulse_capture_top
// Path: input register, then result register. Throughput: one item per
// cycle while the result channel does not stall, set by the per-channel
// compare and update behind the input register.
// Reset: synchronous, active low; registers take their defaults, channels
// are cleared and no result is pending.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_capture_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rcpwm_pkg::CMD_W-1:0]         in_cmd,
  input  logic [rcpwm_pkg::CHAN_W-1:0]        in_chan,
  input  logic                                in_level,
  input  logic [rcpwm_pkg::STAMP_W-1:0]       in_stamp,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rcpwm_pkg::STATUS_W-1:0]      out_status,
  output logic [rcpwm_pkg::PULSE_W-1:0]       out_width_value,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcpwm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NCH = rcpwm_pkg::NUM_CHANNELS;

  // configuration registers
  logic [rcpwm_pkg::ENABLE_W-1:0] enable_mask_r;
  logic [rcpwm_pkg::PULSE_W-1:0]  pulse_min_r;
  logic [rcpwm_pkg::PULSE_W-1:0]  pulse_max_r;
  logic [rcpwm_pkg::STAMP_W-1:0]  lost_timeout_r;
  logic [rcpwm_pkg::PULSE_W-1:0]  mid_value_r;
  logic [rcpwm_pkg::PULSE_W-1:0]  throttle_low_r;

  // per-channel state
  logic [rcpwm_pkg::STAMP_W-1:0] rise_time_r      [NCH];
  logic [rcpwm_pkg::STAMP_W-1:0] last_good_time_r [NCH];
  logic [rcpwm_pkg::PULSE_W-1:0] pulse_width_r    [NCH];
  logic [NCH-1:0]                fresh_r;

  logic [rcpwm_pkg::STAMP_W-1:0] rise_time_nxt      [NCH];
  logic [rcpwm_pkg::STAMP_W-1:0] last_good_time_nxt [NCH];
  logic [rcpwm_pkg::PULSE_W-1:0] pulse_width_nxt    [NCH];
  logic [NCH-1:0]                fresh_nxt;

  // input register
  logic                           in_vld_r;
  logic [rcpwm_pkg::CMD_W-1:0]    cmd_r;
  logic [rcpwm_pkg::CHAN_W-1:0]   chan_r;
  logic                           level_r;
  logic [rcpwm_pkg::STAMP_W-1:0]  stamp_r;

  // result register
  logic                            out_vld_r;
  logic [rcpwm_pkg::STATUS_W-1:0]  out_status_r;
  logic [rcpwm_pkg::PULSE_W-1:0]   out_width_r;

  // combinational results
  logic                            has_res;
  logic [rcpwm_pkg::STATUS_W-1:0]  res_status;
  logic [rcpwm_pkg::PULSE_W-1:0]   res_width;
  logic                            out_take;
  logic                            adv;
  logic                            cfg_wr;

  logic [NCH-1:0]                  en_vec;
  logic [NCH-1:0]                  lost_vec;
  logic [rcpwm_pkg::IDX_W-1:0]     idx;
  logic                            chan_in_range;
  logic                            chan_en;
  logic [rcpwm_pkg::STAMP_W-1:0]   edge_width;
  logic [rcpwm_pkg::PULSE_W-1:0]   chan_dflt;

  // handshake
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign out_take  = !out_vld_r || !out_stall;
  assign adv       = in_vld_r && (!has_res || out_take);
  assign in_stall  = in_vld_r && !adv;

  assign out_valid       = out_vld_r;
  assign out_status      = out_status_r;
  assign out_width_value = out_width_r;

  // channel decode
  assign idx           = chan_r[rcpwm_pkg::IDX_W-1:0];
  assign chan_in_range = (int'(chan_r) < NCH);
  assign chan_en       = chan_in_range && en_vec[idx];
  assign chan_dflt     = (int'(chan_r) == rcpwm_pkg::THROTTLE_CHANNEL) ?
                         throttle_low_r : mid_value_r;
  assign edge_width    = stamp_r - rise_time_r[idx];

  // enable and lost flags per channel
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      en_vec[c]   = (c < rcpwm_pkg::ENABLE_W) ?
                    enable_mask_r[c % rcpwm_pkg::ENABLE_W] : 1'b0;
      lost_vec[c] = en_vec[c] && ((last_good_time_r[c] == '0) ||
                    ((stamp_r - last_good_time_r[c]) > lost_timeout_r));
    end
  end

  // item processing: state next values and result
  always_comb begin
    logic any_en;
    logic stop;
    logic any_fresh;
    rise_time_nxt      = rise_time_r;
    last_good_time_nxt = last_good_time_r;
    pulse_width_nxt    = pulse_width_r;
    fresh_nxt          = fresh_r;
    has_res            = 1'b0;
    res_status         = rcpwm_pkg::STATUS_LOST;
    res_width          = '0;
    any_en             = 1'b0;
    stop               = 1'b0;
    any_fresh          = 1'b0;
    unique case (rcpwm_pkg::cmd_t'(cmd_r))
      rcpwm_pkg::CMD_EDGE: begin
        if (chan_en) begin
          if (level_r) begin
            rise_time_nxt[idx] = stamp_r;
          end else if (rise_time_r[idx] != '0) begin
            if ((edge_width >= {16'd0, pulse_min_r}) &&
                (edge_width <= {16'd0, pulse_max_r})) begin
              pulse_width_nxt[idx]    = edge_width[rcpwm_pkg::PULSE_W-1:0];
              last_good_time_nxt[idx] = stamp_r;
              fresh_nxt[idx]          = 1'b1;
            end
          end
        end
      end
      rcpwm_pkg::CMD_POLL: begin
        has_res = 1'b1;
        // walk in channel order, clearing flags until the first lost one
        for (int c = 0; c < NCH; c++) begin
          if (en_vec[c]) begin
            any_en = 1'b1;
            if (lost_vec[c]) begin
              stop = 1'b1;
            end
            if (!stop) begin
              any_fresh    = any_fresh | fresh_r[c];
              fresh_nxt[c] = 1'b0;
            end
          end
        end
        if (!any_en || stop) begin
          res_status = rcpwm_pkg::STATUS_LOST;
        end else if (any_fresh) begin
          res_status = rcpwm_pkg::STATUS_RECEIVED;
        end else begin
          res_status = rcpwm_pkg::STATUS_IDLE;
        end
      end
      rcpwm_pkg::CMD_READ: begin
        has_res = 1'b1;
        if (!chan_in_range) begin
          res_width = mid_value_r;
        end else if (!chan_en) begin
          res_width = chan_dflt;
        end else begin
          res_width = pulse_width_r[idx];
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r  <= '0;
      pulse_min_r    <= rcpwm_pkg::PULSE_MIN_RST;
      pulse_max_r    <= rcpwm_pkg::PULSE_MAX_RST;
      lost_timeout_r <= rcpwm_pkg::LOST_TIMEOUT_RST;
      mid_value_r    <= rcpwm_pkg::MID_VALUE_RST;
      throttle_low_r <= rcpwm_pkg::THROTTLE_LOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rcpwm_pkg::REG_ENABLE_MASK:  enable_mask_r  <= cfg_data[rcpwm_pkg::ENABLE_W-1:0];
        rcpwm_pkg::REG_PULSE_MIN:    pulse_min_r    <= cfg_data[rcpwm_pkg::PULSE_W-1:0];
        rcpwm_pkg::REG_PULSE_MAX:    pulse_max_r    <= cfg_data[rcpwm_pkg::PULSE_W-1:0];
        rcpwm_pkg::REG_LOST_TIMEOUT: lost_timeout_r <= cfg_data;
        rcpwm_pkg::REG_MID_VALUE:    mid_value_r    <= cfg_data[rcpwm_pkg::PULSE_W-1:0];
        rcpwm_pkg::REG_THROTTLE_LOW: throttle_low_r <= cfg_data[rcpwm_pkg::PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // channel state: cleared on reset and on an enable mask write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        rise_time_r[c]      <= '0;
        last_good_time_r[c] <= '0;
        pulse_width_r[c]    <= (c == rcpwm_pkg::THROTTLE_CHANNEL) ?
                               rcpwm_pkg::THROTTLE_LOW_RST : rcpwm_pkg::MID_VALUE_RST;
      end
      fresh_r <= '0;
    end else if (cfg_wr && (cfg_index == rcpwm_pkg::REG_ENABLE_MASK)) begin
      for (int c = 0; c < NCH; c++) begin
        rise_time_r[c]      <= '0;
        last_good_time_r[c] <= '0;
        pulse_width_r[c]    <= (c == rcpwm_pkg::THROTTLE_CHANNEL) ?
                               throttle_low_r : mid_value_r;
      end
      fresh_r <= '0;
    end else if (adv) begin
      rise_time_r      <= rise_time_nxt;
      last_good_time_r <= last_good_time_nxt;
      pulse_width_r    <= pulse_width_nxt;
      fresh_r          <= fresh_nxt;
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= in_cmd;
      chan_r  <= in_chan;
      level_r <= in_level;
      stamp_r <= in_stamp;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && has_res) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      out_status_r <= res_status;
      out_width_r  <= res_width;
    end
  end

endmodule
